### rtl/pls_pkg.sv
// shared constants, codes and types of the positional list store
`default_nettype none
package pls_pkg;

   localparam int DEPTH = 16;
   localparam int WIDTH = 32;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

   localparam int REQ_W  = 3;
   localparam int POS_W  = 5;
   localparam int DIN_W  = 32;
   localparam int DOUT_W = 32;
   localparam int ICNT_W = 5;
   localparam int STAT_W = 2;

   localparam logic [REQ_W-1:0] REQ_APPEND  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_REMOVE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_WRITE   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_RESTART = 3'd5;
   localparam logic [REQ_W-1:0] REQ_ADVANCE = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_BADPOS  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_PASTEND = 2'd3;

   typedef struct packed {
      logic             ins;
      logic             rem;
      logic             wr;
      logic [IDX_W-1:0] idx;
      logic [WIDTH-1:0] data;
   } cell_ctrl_type;

   // fit an input word to the stored width
   function automatic logic [WIDTH-1:0] fit_data(input logic [DIN_W-1:0] d);
      logic [63:0] t;
      t = 64'(d);
      return t[WIDTH-1:0];
   endfunction

   // fit a stored word to the output width
   function automatic logic [DOUT_W-1:0] out_data(input logic [WIDTH-1:0] d);
      logic [63:0] t;
      t = 64'(d);
      return t[DOUT_W-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/positional_list_store.sv
// top level of the positional list store: control, cell chain and response register
`default_nettype none
// positional list store: an ordered list of up to DEPTH words addressed by
// 1-based position, held in a row of cells that shift together
//
// request channel: a transfer happens at a rising edge with start high and
// busy low; req_type selects append, insert, remove, read, write, cursor
// restart or cursor advance, req_position and req_data_in go with it
//
// response channel: exactly one response per request, shown on the rsp_
// ports for one cycle with rsp_valid high, in the cycle after the request
// transfer; it gives the data word, the count after the request and a status
//
// throughput: one request per cycle while busy is low; insert and remove move every
// cell at once through the neighbor links, and read/advance pick one cell
// through a single select, so no request holds up the next one
//
// reset: count and cursor clear, busy is high while reset is high and until the
// first clock edge after it drops; cell contents are not cleared, only positions
// below count are ever read
//
// the receiver has no way to stall: a response not taken is lost
module positional_list_store (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [pls_pkg::REQ_W-1:0]      req_type,
   input  wire logic [pls_pkg::POS_W-1:0]      req_position,
   input  wire logic [pls_pkg::DIN_W-1:0]      req_data_in,
   output logic                                rsp_valid,
   output logic      [pls_pkg::DOUT_W-1:0]     rsp_data_out,
   output logic      [pls_pkg::ICNT_W-1:0]     rsp_item_count,
   output logic      [pls_pkg::STAT_W-1:0]     rsp_status
);

   // list control state
   logic [pls_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [pls_pkg::CNT_W-1:0]  cursor_ff, cursor_in;
   logic                       busy_ff;

   // response register
   logic                       rsp_valid_ff;
   logic [pls_pkg::DOUT_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pls_pkg::ICNT_W-1:0] rsp_count_ff;
   logic [pls_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic                        accept;
   logic [pls_pkg::CMP_W-1:0]   pos_w;
   logic [pls_pkg::CMP_W-1:0]   cnt_w;
   logic [pls_pkg::CMP_W-1:0]   cur_w;
   logic [pls_pkg::CMP_W-1:0]   pos_m1;
   logic                        full;
   logic                        pos_in_list;   // 1..count
   logic                        pos_in_ins;    // 1..count+1
   logic [pls_pkg::IDX_W-1:0]   rd_idx;
   logic [pls_pkg::WIDTH-1:0]   rd_data;
   pls_pkg::cell_ctrl_type      ctrl;
   logic [pls_pkg::WIDTH-1:0]   cell_q [pls_pkg::DEPTH];

   assign accept = start && !busy_ff;

   // position checks on a common width wide enough for both operands
   assign pos_w  = pls_pkg::CMP_W'(req_position);
   assign cnt_w  = pls_pkg::CMP_W'(count_ff);
   assign cur_w  = pls_pkg::CMP_W'(cursor_ff);
   assign pos_m1 = pos_w - pls_pkg::CMP_W'(1);
   assign full   = (cnt_w >= pls_pkg::CMP_W'(pls_pkg::DEPTH));
   assign pos_in_list = (pos_w != '0) && (pos_w <= cnt_w);
   assign pos_in_ins  = (pos_w != '0) && (pos_w <= cnt_w + pls_pkg::CMP_W'(1));

   // cell select for read and cursor advance; out-of-range picks are never used
   assign rd_idx  = (req_type == pls_pkg::REQ_ADVANCE) ? cursor_ff[pls_pkg::IDX_W-1:0]
                                                       : pos_m1[pls_pkg::IDX_W-1:0];
   assign rd_data = cell_q[rd_idx];

   // request decode: cell commands, next count/cursor, response
   always_comb begin
      ctrl.ins      = 1'b0;
      ctrl.rem      = 1'b0;
      ctrl.wr       = 1'b0;
      ctrl.idx      = pos_m1[pls_pkg::IDX_W-1:0];
      ctrl.data     = pls_pkg::fit_data(req_data_in);
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      rsp_data_in   = '0;
      rsp_status_in = pls_pkg::ST_OK;
      if (accept) begin
         case (req_type)
            pls_pkg::REQ_APPEND: begin
               if (full) begin
                  rsp_status_in = pls_pkg::ST_FULL;
               end else begin
                  ctrl.wr  = 1'b1;
                  ctrl.idx = count_ff[pls_pkg::IDX_W-1:0];
                  count_in = count_ff + pls_pkg::CNT_W'(1);
               end
            end
            pls_pkg::REQ_INSERT: begin
               if (!pos_in_ins) begin
                  rsp_status_in = pls_pkg::ST_BADPOS;
               end else if (full) begin
                  rsp_status_in = pls_pkg::ST_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  count_in = count_ff + pls_pkg::CNT_W'(1);
               end
            end
            pls_pkg::REQ_REMOVE: begin
               if (!pos_in_list) begin
                  rsp_status_in = pls_pkg::ST_BADPOS;
               end else begin
                  ctrl.rem = 1'b1;
                  count_in = count_ff - pls_pkg::CNT_W'(1);
               end
            end
            pls_pkg::REQ_READ: begin
               if (!pos_in_list) begin
                  rsp_status_in = pls_pkg::ST_BADPOS;
               end else begin
                  rsp_data_in = pls_pkg::out_data(rd_data);
               end
            end
            pls_pkg::REQ_WRITE: begin
               if (!pos_in_list) begin
                  rsp_status_in = pls_pkg::ST_BADPOS;
               end else begin
                  ctrl.wr = 1'b1;
               end
            end
            pls_pkg::REQ_RESTART: begin
               cursor_in = '0;
            end
            pls_pkg::REQ_ADVANCE: begin
               // cursor past the end wraps back to before the first element
               if ((cur_w < cnt_w) && (cur_w < pls_pkg::CMP_W'(pls_pkg::DEPTH))) begin
                  cursor_in   = cursor_ff + pls_pkg::CNT_W'(1);
                  rsp_data_in = pls_pkg::out_data(rd_data);
               end else begin
                  cursor_in     = '0;
                  rsp_status_in = pls_pkg::ST_PASTEND;
               end
            end
            default: begin
               // unused code: no change, ok status
            end
         endcase
      end
   end

   // the cell chain; each cell sees its neighbors, the ends see harmless data
   for (genvar i = 0; i < pls_pkg::DEPTH; i++) begin : g_cell
      logic [pls_pkg::WIDTH-1:0] left_d;
      logic [pls_pkg::WIDTH-1:0] right_d;
      if (i == 0) begin : g_first
         assign left_d = ctrl.data;
      end else begin : g_mid_l
         assign left_d = cell_q[i-1];
      end
      if (i == pls_pkg::DEPTH - 1) begin : g_last
         assign right_d = cell_q[i];
      end else begin : g_mid_r
         assign right_d = cell_q[i+1];
      end
      pls_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .my_idx     (pls_pkg::IDX_W'(i)),
         .left_data  (left_d),
         .right_data (right_d),
         .entry      (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
      end
   end

   // response payload, loaded with each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= pls_pkg::ICNT_W'(count_in);
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_item_count = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   // count stays within the cell chain
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pls_pkg::CNT_W'(pls_pkg::DEPTH))
      else $error("list count beyond depth");

   // every transfer gives one response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("request without response");

   // no response without a request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("response without request");

   // a full refusal only happens with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pls_pkg::ST_FULL)
         |-> (rsp_item_count == pls_pkg::ICNT_W'(pls_pkg::DEPTH)))
      else $error("full status with room left");

   // past the end the cursor has wrapped to the start
   a_cursor_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == pls_pkg::ST_PASTEND) |-> (cursor_ff == '0))
      else $error("cursor not cleared after past end");

endmodule
`default_nettype wire

### rtl/pls_cell.sv
// one list cell: holds one entry, shifts from either neighbor
`default_nettype none
module pls_cell (
   input  wire logic                         clock,
   input  wire pls_pkg::cell_ctrl_type       ctrl,
   input  wire logic [pls_pkg::IDX_W-1:0]    my_idx,
   input  wire logic [pls_pkg::WIDTH-1:0]    left_data,
   input  wire logic [pls_pkg::WIDTH-1:0]    right_data,
   output logic      [pls_pkg::WIDTH-1:0]    entry
);

   logic [pls_pkg::WIDTH-1:0] entry_ff;
   logic [pls_pkg::WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (my_idx == ctrl.idx) begin
            entry_in = ctrl.data;
         end else if (my_idx > ctrl.idx) begin
            entry_in = left_data;
         end
      end else if (ctrl.rem) begin
         if (my_idx >= ctrl.idx) begin
            entry_in = right_data;
         end
      end else if (ctrl.wr) begin
         if (my_idx == ctrl.idx) begin
            entry_in = ctrl.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire
